@@ design/rde_pkg.sv @@
// Package for the radix digit emitter: widths, radix limits, state codes,
// the divider status struct and the digit-to-ASCII mapping.
// No dependencies.
package rde_pkg;

  localparam int VALUE_BITS = 31;
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int BITCNT_W   = $clog2(VALUE_BITS);
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int CHAR_W     = 7;

  localparam logic [RADIX_W-1:0]  RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0]  RADIX_MAX   = RADIX_W'(16);
  localparam logic [RADIX_W-1:0]  RADIX_RESET = RADIX_W'(10);
  localparam logic [IDX_W-1:0]    LAST_IDX    = IDX_W'(VALUE_BITS - 1);
  localparam logic [BITCNT_W-1:0] LAST_BIT    = BITCNT_W'(VALUE_BITS - 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(87);  // 'a' minus ten

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } state_e;

  // Status of the serial divider after one step.
  typedef struct packed {
    logic               done;     // last quotient bit produced this cycle
    logic               nonzero;  // quotient of the finished division is not zero
    logic [DIGIT_W-1:0] digit;    // remainder of the finished division
  } div_status_t;

  // Lower-case hexadecimal character for one digit.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_ALPHA + ext;
    end
  endfunction

endpackage

@@ design/rde_divider.sv @@
// Bit-serial restoring divider of the radix digit emitter: one quotient bit
// per cycle while run_i is high, the quotient shifts back into the value register in place.
// Depends on rde_pkg.
module rde_divider import rde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  run_i,
  input  logic [RADIX_W-1:0]    radix_i,
  output div_status_t           status_o
);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [BITCNT_W-1:0]   bit_q, bit_d;
  logic                  nz_q, nz_d;

  logic [RADIX_W-1:0]    partial;
  logic [RADIX_W-1:0]    diff;
  logic                  qbit;
  logic [DIGIT_W-1:0]    rem_next;
  logic                  last_bit;

  assign partial  = {rem_q, val_q[VALUE_BITS-1]};
  assign qbit     = (partial >= radix_i);
  assign diff     = partial - radix_i;
  assign rem_next = qbit ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
  assign last_bit = (bit_q == LAST_BIT);

  always_comb begin
    val_d = val_q;
    rem_d = rem_q;
    bit_d = bit_q;
    nz_d  = nz_q;
    if (load_i) begin
      val_d = value_i;
      rem_d = '0;
      bit_d = '0;
      nz_d  = 1'b0;
    end else if (run_i) begin
      val_d = {val_q[VALUE_BITS-2:0], qbit};
      if (last_bit) begin
        // Restart on the quotient just formed.
        rem_d = '0;
        bit_d = '0;
        nz_d  = 1'b0;
      end else begin
        rem_d = rem_next;
        bit_d = bit_q + BITCNT_W'(1);
        nz_d  = nz_q | qbit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
      nz_q  <= 1'b0;
    end else begin
      bit_q <= bit_d;
      nz_q  <= nz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign status_o.done    = run_i & last_bit;
  assign status_o.nonzero = nz_q | qbit;
  assign status_o.digit   = rem_next;

endmodule

@@ design/rde_digit_ram.sv @@
// Digit store of the radix digit emitter: one write port, one read port
// with registered read data. Depends on rde_pkg.
module rde_digit_ram import rde_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [DIGIT_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output logic [DIGIT_W-1:0] rd_data_o
);

  logic [DIGIT_W-1:0] mem_q [2**IDX_W];
  logic [DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/radix_digit_emitter.sv @@
// Converts a non-negative integer to lower-case ASCII digits in the base held
// in the radix register (2 to 16, out-of-range writes saturate, reset 10),
// most significant digit first, with last_o marking the final digit; zero
// gives a single '0'. One item is handled at a time. A bit-serial divider
// forms the digits least significant first, and each digit is then read from
// the digit store and shown; output stalls hold a shown digit until taken.
// Depends on rde_pkg, rde_divider and rde_digit_ram.
module radix_digit_emitter import rde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [RADIX_W-1:0]    cfg_radix_i
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [RADIX_W-1:0] radix_q, radix_d;

  logic               in_accept;
  logic               div_run;
  div_status_t        div_status;
  logic               wr_en;
  logic               rd_en;
  logic [DIGIT_W-1:0] rd_data;

  assign in_accept = in_valid_i & ~in_stall_o;

  rde_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_accept),
    .value_i (value_i),
    .run_i   (div_run),
    .radix_i (radix_q),
    .status_o(div_status)
  );

  rde_digit_ram u_digit_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(idx_q),
    .wr_data_i(div_status.digit),
    .rd_en_i  (rd_en),
    .rd_addr_i(idx_q),
    .rd_data_o(rd_data)
  );

  always_comb begin
    radix_d = radix_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_radix_i < RADIX_MIN) begin
        radix_d = RADIX_MIN;
      end else if (cfg_radix_i > RADIX_MAX) begin
        radix_d = RADIX_MAX;
      end else begin
        radix_d = cfg_radix_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    div_run     = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_valid_o = 1'b0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_run = 1'b1;
        if (div_status.done) begin
          wr_en = 1'b1;
          // Stop once the quotient is zero or the store is full; idx then
          // points at the most significant digit.
          if (!div_status.nonzero || idx_q == LAST_IDX) begin
            state_d = ST_READ;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - IDX_W'(1);
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      radix_q <= RADIX_RESET;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      radix_q <= radix_d;
    end
  end

  assign digit_char_o = digit_to_char(rd_data);
  assign last_o       = (idx_q == '0);

  // No new word is taken while a digit is on offer.
  a_no_input_while_showing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o
  ) else $error("input accepted while a digit is shown");

  // An accepted word starts a division at once, with no digit shown yet.
  a_accept_starts_division: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (in_stall_o && !out_valid_o && !cfg_ready_o)
  ) else $error("accepted word did not start a division");

  // The stored radix always stays within two to sixteen.
  a_radix_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX)
  ) else $error("radix register out of range");

  // Once the last digit is taken, the block is idle again with no digit shown.
  a_last_ends_run: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o && !in_stall_o
  ) else $error("run did not end after the last digit");

endmodule

@@ sim/tb_radix_digit_emitter.sv @@
`timescale 1ns / 100ps
// Testbench for radix_digit_emitter: converts values through its own digit predictor
// and checks every emitted character and last mark, under random input and output gaps.
// Depends on rde_pkg and the radix_digit_emitter RTL.
module tb_radix_digit_emitter;
  import rde_pkg::*;

  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_ITEMS   = 240;
  localparam logic [7:0] ASCII_ZERO = "0";
  localparam logic [7:0] ASCII_A    = "a";
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_word_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [VALUE_BITS-1:0] value_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CHAR_W-1:0]     digit_char_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [RADIX_W-1:0]    cfg_radix_i = '0;

  digit_word_t        pending_digits[$];
  digit_word_t        want;
  logic [RADIX_W-1:0] radix_copy = RADIX_RESET;
  int                 errors        = 0;
  bit                 no_gaps       = 1'b0;
  int                 hold_requests = 0;
  int                 holds_seen    = 0;
  int                 hold_left     = 0;
  int                 quiet_cycles  = 0;

  radix_digit_emitter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_radix_i  (cfg_radix_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Out-of-range register values saturate into the two to sixteen window.
  function automatic int unsigned effective_base();
    if (radix_copy < RADIX_MIN) return RADIX_MIN;
    if (radix_copy > RADIX_MAX) return RADIX_MAX;
    return radix_copy;
  endfunction

  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
    logic [DIGIT_W-1:0] rem_store [VALUE_BITS];
    longint unsigned    rest;
    int unsigned        base;
    int                 n;
    digit_word_t        w;
    base = effective_base();
    rest = v;
    n = 0;
    do begin
      rem_store[n] = DIGIT_W'(rest % base);
      n++;
      rest = rest / base;
    end while (rest != 0 && n < VALUE_BITS);
    for (int k = n - 1; k >= 0; k--) begin
      if (rem_store[k] < DIGIT_W'(10)) begin
        w.ch = CHAR_W'(ASCII_ZERO) + CHAR_W'(rem_store[k]);
      end else begin
        w.ch = CHAR_W'(ASCII_A) + CHAR_W'(rem_store[k]) - CHAR_W'(10);
      end
      w.last = (k == 0);
      pending_digits.push_back(w);
    end
  endfunction

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_digits(v);
  endtask

  // Lets every outstanding digit arrive so the block is idle again.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radix_copy = r;
  endtask

  // Values around powers of the current base, where the digit count changes.
  function automatic logic [VALUE_BITS-1:0] boundary_value();
    longint unsigned p;
    int unsigned     base;
    int              steps;
    base  = effective_base();
    steps = $urandom_range(0, VALUE_BITS);
    p = 1;
    while (steps > 0 && p * base <= VALUE_MAX) begin
      p = p * base;
      steps--;
    end
    if ($urandom_range(0, 1) && p > 1) p = p - 1;
    return VALUE_BITS'(p);
  endfunction

  task automatic test_reset_base();
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value(VALUE_BITS'(9));
    send_value(VALUE_BITS'(10));
    send_value(VALUE_BITS'(1000000000));
    send_value(VALUE_MAX);
  endtask

  task automatic test_base_extremes();
    write_radix(RADIX_MIN);
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
    send_value(VALUE_MAX);
    write_radix(RADIX_MAX);
    send_value('0);
    send_value(VALUE_BITS'(15));
    send_value(VALUE_BITS'(16));
    send_value(VALUE_BITS'(32'h5a5a_5a5a));
    send_value(VALUE_MAX);
  endtask

  task automatic test_base_saturation();
    write_radix(RADIX_W'(0));
    send_value(VALUE_BITS'(5));
    write_radix(RADIX_W'(1));
    send_value(VALUE_BITS'(6));
    write_radix(RADIX_W'(31));
    send_value(VALUE_BITS'(255));
    write_radix(RADIX_W'(17));
    send_value(VALUE_BITS'(16));
    write_radix(RADIX_W'(3));
    send_value(VALUE_MAX);
    write_radix(RADIX_W'(7));
    send_value(VALUE_BITS'(48));
  endtask

  // The receiver holds off long enough for the block to stop taking input.
  task automatic test_back_pressure();
    write_radix(RADIX_W'(10));
    no_gaps = 1'b1;
    hold_requests++;
    repeat (8) send_value(VALUE_BITS'($urandom));
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_no_gaps();
    write_radix(RADIX_W'(16));
    no_gaps = 1'b1;
    repeat (30) send_value(VALUE_BITS'($urandom));
    drain();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_bases();
    int sent;
    int pick;
    logic [VALUE_BITS-1:0] v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_radix(RADIX_W'($urandom_range(0, 31)));
      repeat ($urandom_range(10, 40)) begin
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
          v = VALUE_BITS'($urandom);
        end else if (pick == 2) begin
          v = VALUE_BITS'($urandom_range(0, 300));
        end else begin
          v = boundary_value();
        end
        send_value(v);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_base();
    test_base_extremes();
    test_base_saturation();
    test_back_pressure();
    test_no_gaps();
    test_random_bases();
    if (errors == 0) begin
      $display("tb_radix_digit_emitter: clean");
    end else begin
      $display("tb_radix_digit_emitter: errors");
    end
    $finish;
  end

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected word: digit_char %0d last %0d", digit_char_o, last_o);
        errors++;
      end else begin
        want = pending_digits.pop_front();
        if (digit_char_o !== want.ch) begin
          $error("digit_char: expected %0d, actual %0d", want.ch, digit_char_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          errors++;
        end
      end
    end
    if (holds_seen != hold_requests) begin
      holds_seen = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (no_gaps) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  // Ends the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_radix_digit_emitter: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
design/rde_pkg.sv
design/rde_divider.sv
design/rde_digit_ram.sv
design/radix_digit_emitter.sv
sim/tb_radix_digit_emitter.sv
